[rtl/bfhs_pkg.sv]
// Shared types and constants for the bitstream file header stripper.
// Holds the channel payload structs, parse phase encoding and error codes.
// No dependencies.
package bfhs_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_marker;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [2:0]  error_code;
    logic [31:0] payload_length;
  } out_t;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  // Error codes
  localparam logic [2:0] ERR_BAD_LEN9   = 3'd0;
  localparam logic [2:0] ERR_BAD_ONE    = 3'd1;
  localparam logic [2:0] ERR_NOT_KEY_A  = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd3;
  localparam logic [2:0] ERR_NO_PAYLOAD = 3'd4;

  // Header constants
  localparam logic [15:0] HDR_LEN9  = 16'd9;
  localparam logic [15:0] HDR_ONE   = 16'd1;
  localparam logic [15:0] SKIP9_LEN = 16'd9;
  localparam logic [7:0]  KEY_A     = 8'h61;
  localparam logic [7:0]  KEY_B     = 8'h62;
  localparam logic [7:0]  KEY_C     = 8'h63;
  localparam logic [7:0]  KEY_D     = 8'h64;
  localparam logic [7:0]  KEY_E     = 8'h65;

  typedef enum logic [10:0] {
    PH_LEN9    = 11'b000_0000_0001,
    PH_SKIP9   = 11'b000_0000_0010,
    PH_ONE     = 11'b000_0000_0100,
    PH_KEYA    = 11'b000_0000_1000,
    PH_ALEN    = 11'b000_0001_0000,
    PH_SKIP    = 11'b000_0010_0000,
    PH_KEY     = 11'b000_0100_0000,
    PH_FLEN    = 11'b000_1000_0000,
    PH_ELEN    = 11'b001_0000_0000,
    PH_PAYLOAD = 11'b010_0000_0000,
    PH_DONE    = 11'b100_0000_0000
  } phase_e;

  // Parser result toward the output register
  typedef struct packed {
    logic   valid;
    phase_e phase;
    out_t   item;
  } res_t;

endpackage

[rtl/bfhs_parser.sv]
// Header parse state machine for the bitstream file header stripper.
// Holds all parse state and forms at most one result per accepted byte.
// Depends on bfhs_pkg.
module bfhs_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  bfhs_pkg::in_t in_data_i,
  output bfhs_pkg::res_t res_o
);
  import bfhs_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [1:0]             pos_q, pos_d;
  logic [23:0]            acc_q, acc_d;
  logic [15:0]            skip_q, skip_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [LENGTH_BITS-1:0] decl_q, decl_d;

  logic [7:0]             b;
  logic [15:0]            field16;
  logic [31:0]            field32;
  logic [LENGTH_BITS-1:0] len_v;

  assign b       = in_data_i.file_byte;
  assign field16 = {acc_q[7:0], b};
  assign field32 = {acc_q, b};

  // Saturate the declared length to the counter width
  always_comb begin
    if ((field32 >> LENGTH_BITS) != 32'd0) begin
      len_v = '1;
    end else begin
      len_v = field32[LENGTH_BITS-1:0];
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    skip_d  = skip_q;
    rem_d   = rem_q;
    decl_d  = decl_q;

    res_o                     = '0;
    res_o.phase               = phase_q;
    res_o.item.payload_length = 32'(decl_q);

    if (step_i) begin
      if (in_data_i.end_marker) begin
        if (phase_q != PH_DONE) begin
          res_o.valid           = 1'b1;
          res_o.item.kind       = KIND_ERROR;
          res_o.item.error_code = (phase_q == PH_KEY) ? ERR_NO_PAYLOAD : ERR_TRUNCATED;
        end
        // Re-arm
        phase_d = PH_LEN9;
        pos_d   = '0;
        acc_d   = '0;
        skip_d  = '0;
        rem_d   = '0;
        decl_d  = '0;
      end else begin
        unique case (phase_q)
          PH_LEN9, PH_ONE, PH_ALEN, PH_FLEN: begin
            if (pos_q == 2'd0) begin
              acc_d = {16'd0, b};
              pos_d = 2'd1;
            end else begin
              acc_d = {acc_q[15:0], b};
              pos_d = 2'd0;
              if (phase_q == PH_LEN9) begin
                if (field16 != HDR_LEN9) begin
                  res_o.valid           = 1'b1;
                  res_o.item.kind       = KIND_ERROR;
                  res_o.item.error_code = ERR_BAD_LEN9;
                  phase_d               = PH_DONE;
                end else begin
                  skip_d  = SKIP9_LEN;
                  phase_d = PH_SKIP9;
                end
              end else if (phase_q == PH_ONE) begin
                if (field16 != HDR_ONE) begin
                  res_o.valid           = 1'b1;
                  res_o.item.kind       = KIND_ERROR;
                  res_o.item.error_code = ERR_BAD_ONE;
                  phase_d               = PH_DONE;
                end else begin
                  phase_d = PH_KEYA;
                end
              end else begin
                skip_d  = field16;
                phase_d = (field16 != 16'd0) ? PH_SKIP : PH_KEY;
              end
            end
          end
          PH_SKIP9, PH_SKIP: begin
            skip_d = skip_q - 16'd1;
            if (skip_q == 16'd1) begin
              phase_d = (phase_q == PH_SKIP9) ? PH_ONE : PH_KEY;
            end
          end
          PH_KEYA: begin
            if (b != KEY_A) begin
              res_o.valid           = 1'b1;
              res_o.item.kind       = KIND_ERROR;
              res_o.item.error_code = ERR_NOT_KEY_A;
              phase_d               = PH_DONE;
            end else begin
              phase_d = PH_ALEN;
            end
          end
          PH_KEY: begin
            // Other key bytes are ignored
            if (b == KEY_B || b == KEY_C || b == KEY_D) begin
              pos_d   = 2'd0;
              phase_d = PH_FLEN;
            end else if (b == KEY_E) begin
              pos_d   = 2'd0;
              phase_d = PH_ELEN;
            end
          end
          PH_ELEN: begin
            acc_d = {acc_q[15:0], b};
            if (pos_q == 2'd3) begin
              pos_d                     = 2'd0;
              decl_d                    = len_v;
              rem_d                     = len_v;
              res_o.item.payload_length = 32'(len_v);
              if (len_v == '0) begin
                res_o.valid           = 1'b1;
                res_o.item.kind       = KIND_ERROR;
                res_o.item.error_code = ERR_NO_PAYLOAD;
                phase_d               = PH_DONE;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end else begin
              pos_d = pos_q + 2'd1;
            end
          end
          PH_PAYLOAD: begin
            rem_d                   = rem_q - LENGTH_BITS'(1);
            res_o.valid             = 1'b1;
            res_o.item.kind         = KIND_PAYLOAD;
            res_o.item.payload_byte = b;
            res_o.item.last_payload = (rem_q == LENGTH_BITS'(1));
            if (rem_q == LENGTH_BITS'(1)) begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            // Finished: drop bytes until end of file
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN9;
      pos_q   <= '0;
      acc_q   <= '0;
      skip_q  <= '0;
      rem_q   <= '0;
      decl_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      skip_q  <= skip_d;
      rem_q   <= rem_d;
      decl_q  <= decl_d;
    end
  end

endmodule

[rtl/bit_file_header_stripper_unit.sv]
// Bitstream file header stripper: checks the file header, skips keyed fields
// and forwards the payload bytes that follow key 'e'.
//
// Input channel: one transfer per file byte (in_data_i.file_byte), or an
// end-of-file transfer (in_data_i.end_marker set) that re-arms the parser.
// Output channel: one transfer per payload byte (kind 0, last_payload on
// the final byte) or per error report (kind 1 with error_code); header and
// skipped bytes give no transfer.
// Latency: a result is presented the cycle after the input transfer that
// causes it, from the output register.
// Throughput: one byte per cycle. The parser updates its counters and
// compares combinationally, so the only limit is the one-entry output
// register, which frees whenever the receiver takes its content.
// Receiver stall: while the output register is full and out_ready_i is low,
// in_ready_o is low and the parser holds its state.
// Reset: the parser waits for the first header byte; the output register is
// empty. After a completed payload or an error, bytes are dropped until an
// end-of-file transfer arrives.
// Depends on bfhs_pkg and bfhs_parser.
module bit_file_header_stripper_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfhs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfhs_pkg::out_t out_data_o
);
  import bfhs_pkg::*;

  logic in_fire;
  res_t res;
  logic out_valid_q, out_valid_d;
  out_t out_data_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  bfhs_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_fire),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d = res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result register on every input transfer that yields a result
  always_ff @(posedge clk_i) begin
    if (in_fire && res.valid) begin
      out_data_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled while output register empty");

  a_eof_rearms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_marker |=> res.phase == PH_LEN9)
    else $error("end of file did not re-arm parser");

  a_error_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_ERROR |->
      !out_data_o.last_payload && out_data_o.payload_byte == 8'd0)
    else $error("error report carries payload fields");

  a_payload_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_PAYLOAD |->
      out_data_o.error_code == ERR_BAD_LEN9 && out_data_o.payload_length != 32'd0)
    else $error("payload transfer with error code or zero length");
`endif

endmodule

[sim/bit_file_header_stripper_unit_test.sv]
// Self-checking testbench for bit_file_header_stripper_unit: sends bitstream files
// byte by byte, predicts payload bytes and error reports, and checks every output transfer.
// Depends on bfhs_pkg and the RTL of the stripper.
module bit_file_header_stripper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfhs_pkg::*;

  localparam int          LEN_BITS    = 32;
  localparam int          DRAIN_LIMIT = 5000;
  localparam logic [2:0]  NO_ERROR    = 3'd0;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  bit_file_header_stripper_unit #(
    .LENGTH_BITS(LEN_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Parser shadow state
  phase_e      ph;
  logic [1:0]  fpos;
  logic [31:0] facc;
  logic [15:0] skip_left;
  logic [31:0] pay_left;
  logic [31:0] decl_len;

  out_t        stripped_q[$];
  logic [7:0]  image_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned files_sent = 0;
  int unsigned payload_seen = 0;
  int unsigned errors_seen = 0;

  task automatic clear_parser();
    ph        = PH_LEN9;
    fpos      = '0;
    facc      = '0;
    skip_left = '0;
    pay_left  = '0;
    decl_len  = '0;
  endtask

  // Shift one byte into a big-endian field; true once the field is complete.
  function automatic bit take_field_byte(input logic [7:0] b, input int unsigned nbytes);
    if (fpos == 2'd0) facc = {24'd0, b};
    else facc = {facc[23:0], b};
    if (32'(fpos) + 32'd1 >= nbytes) begin
      fpos = 2'd0;
      return 1'b1;
    end
    fpos = fpos + 2'd1;
    return 1'b0;
  endfunction

  task automatic push_result(logic kind, logic [7:0] pb, logic last, logic [2:0] code);
    out_t r;
    r.kind           = kind;
    r.payload_byte   = pb;
    r.last_payload   = last;
    r.error_code     = code;
    r.payload_length = decl_len;
    stripped_q.push_back(r);
  endtask

  task automatic report_error(logic [2:0] code);
    push_result(KIND_ERROR, 8'd0, 1'b0, code);
    ph = PH_DONE;
  endtask

  task automatic strip_byte(in_t item);
    logic [7:0]  b;
    logic [32:0] max_len;
    b       = item.file_byte;
    max_len = (33'd1 << LEN_BITS) - 33'd1;
    if (item.end_marker) begin
      if (ph != PH_DONE)
        push_result(KIND_ERROR, 8'd0, 1'b0, (ph == PH_KEY) ? ERR_NO_PAYLOAD : ERR_TRUNCATED);
      clear_parser();
    end else begin
      case (ph)
        PH_LEN9: if (take_field_byte(b, 2)) begin
          if (facc[15:0] != HDR_LEN9) begin
            report_error(ERR_BAD_LEN9);
          end else begin
            skip_left = SKIP9_LEN;
            ph = PH_SKIP9;
          end
        end
        PH_SKIP9: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) ph = PH_ONE;
        end
        PH_ONE: if (take_field_byte(b, 2)) begin
          if (facc[15:0] != HDR_ONE) report_error(ERR_BAD_ONE);
          else ph = PH_KEYA;
        end
        PH_KEYA: begin
          if (b != KEY_A) report_error(ERR_NOT_KEY_A);
          else ph = PH_ALEN;
        end
        PH_ALEN, PH_FLEN: if (take_field_byte(b, 2)) begin
          skip_left = facc[15:0];
          ph = (skip_left != 16'd0) ? PH_SKIP : PH_KEY;
        end
        PH_SKIP: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) ph = PH_KEY;
        end
        PH_KEY: begin
          if (b == KEY_B || b == KEY_C || b == KEY_D) begin
            fpos = 2'd0;
            ph = PH_FLEN;
          end else if (b == KEY_E) begin
            fpos = 2'd0;
            ph = PH_ELEN;
          end
        end
        PH_ELEN: if (take_field_byte(b, 4)) begin
          decl_len = ({1'b0, facc} > max_len) ? max_len[31:0] : facc;
          pay_left = decl_len;
          if (decl_len == 32'd0) report_error(ERR_NO_PAYLOAD);
          else ph = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          pay_left = pay_left - 32'd1;
          push_result(KIND_PAYLOAD, b, pay_left == 32'd0, NO_ERROR);
          if (pay_left == 32'd0) ph = PH_DONE;
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Check each output transfer against the oldest prediction, then pick the next ready.
  always @(posedge clk_i) begin : check_outputs
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stripped_q.size() == 0) begin
        $error("output transfer with nothing expected: 0x%0h", out_data_o);
        mismatch_count++;
      end else begin
        want = stripped_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data_o.kind));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_data_o.payload_byte));
        check_field("last_payload", 32'(want.last_payload), 32'(out_data_o.last_payload));
        check_field("error_code", 32'(want.error_code), 32'(out_data_o.error_code));
        check_field("payload_length", want.payload_length, out_data_o.payload_length);
        if (want.kind == KIND_ERROR) errors_seen++;
        else payload_seen++;
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hold valid once raised; predict at the transfer edge.
  task automatic send_item(in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    strip_byte(item);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(in_t'{file_byte: b, end_marker: 1'b0});
  endtask

  task automatic send_eof();
    send_item(in_t'{file_byte: 8'($urandom_range(0, 255)), end_marker: 1'b1});
    files_sent++;
  endtask

  task automatic send_word16(logic [15:0] v);
    send_byte(v[15:8]);
    send_byte(v[7:0]);
  endtask

  task automatic send_preamble(logic [7:0] fill);
    send_word16(HDR_LEN9);
    repeat (9) send_byte(fill);
    send_word16(HDR_ONE);
    send_byte(KEY_A);
  endtask

  // Stop sending until every predicted output has been taken or DRAIN_LIMIT is hit.
  task automatic wait_for_outputs();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (stripped_q.size() != 0 && guard < DRAIN_LIMIT);
  endtask

  task automatic test_eof_at_reset();
    send_eof();
  endtask

  task automatic test_bad_length_nine();
    send_word16(16'hFFFF);
    send_byte(8'h55);
    send_eof();
  endtask

  task automatic test_bad_marker_one();
    send_word16(HDR_LEN9);
    repeat (9) send_byte(8'h00);
    send_word16(16'h0000);
    send_eof();
  endtask

  task automatic test_bad_key_a();
    send_word16(HDR_LEN9);
    repeat (9) send_byte(8'hFF);
    send_word16(HDR_ONE);
    send_byte(KEY_B);
    send_eof();
  endtask

  task automatic test_empty_payload();
    send_preamble(8'h5A);
    send_word16(16'h0000);
    send_byte(8'h80);
    send_byte(KEY_E);
    send_word16(16'h0000);
    send_word16(16'h0000);
    send_eof();
  endtask

  task automatic test_eof_before_payload_key();
    send_preamble(8'hA5);
    send_word16(16'h0001);
    send_byte(8'h78);
    send_byte(KEY_C);
    send_word16(16'h0000);
    send_eof();
  endtask

  task automatic test_truncated_payload();
    send_preamble(8'h00);
    send_word16(16'h0000);
    send_byte(KEY_E);
    send_word16(16'hFFFF);
    send_word16(16'hFFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_eof();
  endtask

  task automatic test_complete_file();
    send_preamble(8'hFF);
    send_word16(16'h0002);
    send_byte(8'h78);
    send_byte(8'h79);
    send_byte(KEY_D);
    send_word16(16'h0001);
    send_byte(8'h7A);
    send_byte(KEY_E);
    send_word16(16'h0000);
    send_word16(16'h0002);
    send_byte(8'hFF);
    send_byte(8'h00);
    // trailing byte after the last payload byte is dropped
    send_byte(KEY_E);
    send_eof();
  endtask

  task automatic add_word16(logic [15:0] v);
    image_q.push_back(v[15:8]);
    image_q.push_back(v[7:0]);
  endtask

  task automatic add_random_bytes(int unsigned n);
    repeat (n) image_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Length-prefixed field; a long one is cut short and the file truncated.
  task automatic add_field(output bit cut);
    logic [15:0] len;
    cut = 1'b0;
    if ($urandom_range(0, 99) < 8) len = 16'($urandom_range(0, 65535));
    else len = 16'($urandom_range(0, 4));
    add_word16(len);
    if (len > 16'd12) begin
      cut = 1'b1;
      add_random_bytes($urandom_range(0, 6));
    end else begin
      add_random_bytes(len);
    end
  endtask

  task automatic build_file();
    bit          cut;
    int unsigned r;
    logic [7:0]  k;
    logic [31:0] plen;
    image_q.delete();
    cut = 1'b0;
    add_word16(HDR_LEN9);
    add_random_bytes(9);
    add_word16(HDR_ONE);
    image_q.push_back(KEY_A);
    add_field(cut);
    repeat ($urandom_range(0, 3)) begin
      if (!cut) begin
        if ($urandom_range(0, 3) == 0) begin
          k = 8'($urandom_range(0, 255));
          if (k >= KEY_B && k <= KEY_E) k = ~k;
          image_q.push_back(k);
        end else begin
          image_q.push_back(8'(KEY_B + $urandom_range(0, 2)));
          add_field(cut);
        end
      end
    end
    if (!cut) begin
      image_q.push_back(KEY_E);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        plen = 32'd0;
      end else if (r < 22) begin
        plen = $urandom() | 32'h100;
        cut = 1'b1;
      end else begin
        plen = 32'($urandom_range(1, 6));
      end
      add_word16(plen[31:16]);
      add_word16(plen[15:0]);
      if (cut) add_random_bytes($urandom_range(0, 6));
      else add_random_bytes(plen);
    end
    // corrupt one byte, truncate, or append bytes that get dropped
    if ($urandom_range(0, 99) < 12)
      image_q[$urandom_range(0, image_q.size() - 1)] ^= 8'($urandom_range(1, 255));
    if ($urandom_range(0, 99) < 10) begin
      r = $urandom_range(0, image_q.size() - 1);
      while (image_q.size() > r) void'(image_q.pop_back());
    end
    if (!cut && $urandom_range(0, 99) < 20) add_random_bytes($urandom_range(1, 3));
  endtask

  task automatic test_random_files(int unsigned send_pct, int unsigned recv_pct,
                                   int unsigned quota);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        image_q.delete();
        add_random_bytes($urandom_range(1, 12));
      end else begin
        build_file();
      end
      foreach (image_q[i]) send_byte(image_q[i]);
      send_eof();
      if ($urandom_range(0, 99) < 5) wait_for_outputs();
    end
  endtask

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clear_parser();
    send_idle_pct = 18;
    recv_idle_pct = 82;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_eof_at_reset();
    test_bad_length_nine();
    test_bad_marker_one();
    test_bad_key_a();
    test_empty_payload();
    test_eof_before_payload_key();
    test_truncated_payload();
    test_complete_file();

    test_random_files(18, 82, 200);
    wait_for_outputs();
    test_random_files(82, 18, 200);
    wait_for_outputs();
    test_random_files(0, 0, 200);

    wait_for_outputs();
    repeat (4) @(posedge clk_i);
    if (stripped_q.size() != 0) begin
      $error("%0d expected outputs never arrived", stripped_q.size());
      mismatch_count += stripped_q.size();
    end

    $display("Sent %0d input transfers in %0d files (well-formed, corrupted, truncated, noise).",
             items_sent, files_sent);
    $display("Checked %0d payload bytes and %0d error reports.", payload_seen, errors_seen);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bfhs_pkg.sv
rtl/bfhs_parser.sv
rtl/bit_file_header_stripper_unit.sv
sim/bit_file_header_stripper_unit_test.sv
